>>> design/hsv2rgb_pkg.sv
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam int HueW      = 9;
  localparam int ChanW     = 8;
  localparam int SecW      = 4;
  localparam int RemW      = 6;
  localparam int SectorDeg = 60;
  localparam int FullScale = 255;
  localparam int TermShift = 8;
  localparam int MaxSector = ((1 << HueW) - 1) / SectorDeg;

  localparam logic [SecW-1:0] SEC_RED_UP     = 4'd0;
  localparam logic [SecW-1:0] SEC_GREEN_DOWN = 4'd1;
  localparam logic [SecW-1:0] SEC_GREEN_UP   = 4'd2;
  localparam logic [SecW-1:0] SEC_BLUE_DOWN  = 4'd3;
  localparam logic [SecW-1:0] SEC_BLUE_UP    = 4'd4;

  // after hue split
  typedef struct packed {
    logic             valid;
    logic             gray;
    logic [SecW-1:0]  sector;
    logic [ChanW-1:0] f;
    logic [ChanW-1:0] s;
    logic [ChanW-1:0] v;
  } split_t;

  // after the first product stage
  typedef struct packed {
    logic             valid;
    logic             gray;
    logic [SecW-1:0]  sector;
    logic [ChanW-1:0] v;
    logic [ChanW-1:0] p;
    logic [ChanW-1:0] qa;
    logic [ChanW-1:0] tb;
  } prod_t;

  // all terms ready
  typedef struct packed {
    logic             valid;
    logic             gray;
    logic [SecW-1:0]  sector;
    logic [ChanW-1:0] v;
    logic [ChanW-1:0] p;
    logic [ChanW-1:0] q;
    logic [ChanW-1:0] t;
  } term_t;

endpackage

>>> design/hsv2rgb_hue_split.sv
`timescale 1ns / 1ps

module hsv2rgb_hue_split (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req,
  input  logic [hsv2rgb_pkg::HueW-1:0]  hue,
  input  logic [hsv2rgb_pkg::ChanW-1:0] sat,
  input  logic [hsv2rgb_pkg::ChanW-1:0] val,
  output hsv2rgb_pkg::split_t           split
);

  logic [hsv2rgb_pkg::SecW-1:0]  sec_nxt;
  logic [hsv2rgb_pkg::HueW-1:0]  base;
  logic [hsv2rgb_pkg::RemW-1:0]  rem;
  logic [hsv2rgb_pkg::HueW:0]    rem17;
  hsv2rgb_pkg::split_t           split_r;

  // sector = hue / 60 by threshold compare
  always_comb begin
    sec_nxt = '0;
    base    = '0;
    for (int k = 1; k <= hsv2rgb_pkg::MaxSector; k++) begin
      if (hue >= hsv2rgb_pkg::HueW'(k * hsv2rgb_pkg::SectorDeg)) begin
        sec_nxt = hsv2rgb_pkg::SecW'(k);
        base    = hsv2rgb_pkg::HueW'(k * hsv2rgb_pkg::SectorDeg);
      end
    end
  end

  assign rem   = hsv2rgb_pkg::RemW'(hue - base);
  // rem * 255 / 60 == (rem * 17) >> 2
  assign rem17 = {rem, 4'b0000} + {4'b0000, rem};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r.valid <= 1'b0;
    end else begin
      split_r.valid <= req;
    end
    split_r.gray   <= (sat == '0);
    split_r.sector <= sec_nxt;
    split_r.f      <= rem17[hsv2rgb_pkg::HueW:2];
    split_r.s      <= sat;
    split_r.v      <= val;
  end

  assign split = split_r;

endmodule

>>> design/hsv2rgb_terms.sv
`timescale 1ns / 1ps

module hsv2rgb_terms (
  input  logic                clk,
  input  logic                rst_n,
  input  hsv2rgb_pkg::split_t split,
  output hsv2rgb_pkg::term_t  terms
);

  localparam int W = hsv2rgb_pkg::ChanW;
  localparam logic [W-1:0] Full = W'(hsv2rgb_pkg::FullScale);

  logic [2*W-1:0]     p_prod, sf_prod, sfn_prod, q_prod, t_prod;
  hsv2rgb_pkg::prod_t prod_r;
  hsv2rgb_pkg::term_t terms_r;

  // stage 2: p, s*f, s*(255-f)
  assign p_prod   = split.v * (Full - split.s);
  assign sf_prod  = split.s * split.f;
  assign sfn_prod = split.s * (Full - split.f);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else begin
      prod_r.valid <= split.valid;
    end
    prod_r.gray   <= split.gray;
    prod_r.sector <= split.sector;
    prod_r.v      <= split.v;
    prod_r.p      <= p_prod[2*W-1:hsv2rgb_pkg::TermShift];
    prod_r.qa     <= Full - sf_prod[2*W-1:hsv2rgb_pkg::TermShift];
    prod_r.tb     <= Full - sfn_prod[2*W-1:hsv2rgb_pkg::TermShift];
  end

  // stage 3: q, t
  assign q_prod = prod_r.v * prod_r.qa;
  assign t_prod = prod_r.v * prod_r.tb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      terms_r.valid <= 1'b0;
    end else begin
      terms_r.valid <= prod_r.valid;
    end
    terms_r.gray   <= prod_r.gray;
    terms_r.sector <= prod_r.sector;
    terms_r.v      <= prod_r.v;
    terms_r.p      <= prod_r.p;
    terms_r.q      <= q_prod[2*W-1:hsv2rgb_pkg::TermShift];
    terms_r.t      <= t_prod[2*W-1:hsv2rgb_pkg::TermShift];
  end

  assign terms = terms_r;

endmodule

>>> design/hsv2rgb_select.sv
`timescale 1ns / 1ps

module hsv2rgb_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hsv2rgb_pkg::term_t            terms,
  output logic                          valid,
  output logic [hsv2rgb_pkg::ChanW-1:0] red,
  output logic [hsv2rgb_pkg::ChanW-1:0] green,
  output logic [hsv2rgb_pkg::ChanW-1:0] blue
);

  logic                          valid_r;
  logic [hsv2rgb_pkg::ChanW-1:0] red_r, green_r, blue_r;
  logic [hsv2rgb_pkg::ChanW-1:0] red_nxt, green_nxt, blue_nxt;

  always_comb begin
    if (terms.gray) begin
      red_nxt   = terms.v;
      green_nxt = terms.v;
      blue_nxt  = terms.v;
    end else begin
      case (terms.sector)
        hsv2rgb_pkg::SEC_RED_UP: begin
          red_nxt = terms.v; green_nxt = terms.t; blue_nxt = terms.p;
        end
        hsv2rgb_pkg::SEC_GREEN_DOWN: begin
          red_nxt = terms.q; green_nxt = terms.v; blue_nxt = terms.p;
        end
        hsv2rgb_pkg::SEC_GREEN_UP: begin
          red_nxt = terms.p; green_nxt = terms.v; blue_nxt = terms.t;
        end
        hsv2rgb_pkg::SEC_BLUE_DOWN: begin
          red_nxt = terms.p; green_nxt = terms.q; blue_nxt = terms.v;
        end
        hsv2rgb_pkg::SEC_BLUE_UP: begin
          red_nxt = terms.t; green_nxt = terms.p; blue_nxt = terms.v;
        end
        default: begin
          red_nxt = terms.v; green_nxt = terms.p; blue_nxt = terms.q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= terms.valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign valid = valid_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

>>> design/hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; busy is always low, set by the
// four-stage pipeline (hue split, two product stages, channel select).
// Reset (synchronous, rst_n low) clears all stage valid bits; no output
// strobes until new requests reach the end. The receiver cannot stall.

module hsv_to_rgb_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hsv2rgb_pkg::HueW-1:0]  in_hue,
  input  logic [hsv2rgb_pkg::ChanW-1:0] in_saturation,
  input  logic [hsv2rgb_pkg::ChanW-1:0] in_brightness_value,
  output logic                          out_valid,
  output logic [hsv2rgb_pkg::ChanW-1:0] out_red,
  output logic [hsv2rgb_pkg::ChanW-1:0] out_green,
  output logic [hsv2rgb_pkg::ChanW-1:0] out_blue
);

  hsv2rgb_pkg::split_t split;
  hsv2rgb_pkg::term_t  terms;

  assign busy = 1'b0;

  hsv2rgb_hue_split u_split (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (start & ~busy),
    .hue   (in_hue),
    .sat   (in_saturation),
    .val   (in_brightness_value),
    .split (split)
  );

  hsv2rgb_terms u_terms (
    .clk   (clk),
    .rst_n (rst_n),
    .split (split),
    .terms (terms)
  );

  hsv2rgb_select u_select (
    .clk   (clk),
    .rst_n (rst_n),
    .terms (terms),
    .valid (out_valid),
    .red   (out_red),
    .green (out_green),
    .blue  (out_blue)
  );

endmodule

>>> design/hsv2rgb_checker.sv
`timescale 1ns / 1ps

module hsv2rgb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [hsv2rgb_pkg::HueW-1:0]  in_hue,
  input logic [hsv2rgb_pkg::ChanW-1:0] in_saturation,
  input logic [hsv2rgb_pkg::ChanW-1:0] in_brightness_value,
  input logic                          out_valid,
  input logic [hsv2rgb_pkg::ChanW-1:0] out_red,
  input logic [hsv2rgb_pkg::ChanW-1:0] out_green,
  input logic [hsv2rgb_pkg::ChanW-1:0] out_blue
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_req_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("request lost");

  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("spurious result");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_saturation == '0) |-> ##4
      (out_red == out_green && out_green == out_blue &&
       out_red == $past(in_brightness_value, 4)))
    else $error("gray result wrong");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_chk (.*);
